FILE: rtl/vector_terminal_coord_encoder_defines.svh
// assertion macros for the vector terminal coordinate encoder
// used by modules that carry concurrent checks; expects clk and arst_n in scope
`ifndef VECTOR_TERMINAL_COORD_ENCODER_DEFINES_SVH
`define VECTOR_TERMINAL_COORD_ENCODER_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define VTCE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition that must hold in the cycle after a trigger
`define VTCE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/vtce_pkg.sv
// shared types and constants of the vector terminal coordinate encoder
// no dependencies; imported by every module of the block
package vtce_pkg;

	// configuration register indexes
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam int unsigned LIMIT_W = 13;
	localparam int unsigned COORD_W = 16;
	localparam int unsigned FIELD_W = 5;
	localparam int unsigned EXTRA_W = 4;
	localparam int unsigned BYTE_W  = 7;

	// tag bits of the address bytes
	localparam logic [BYTE_W-1:0] TAG_HIGH  = 7'h20;
	localparam logic [BYTE_W-1:0] TAG_LOW_Y = 7'h60;
	localparam logic [BYTE_W-1:0] TAG_LOW_X = 7'h40;

	// byte positions in the send mask, in wire order
	localparam int unsigned POS_HY = 0;
	localparam int unsigned POS_EX = 1;
	localparam int unsigned POS_LY = 2;
	localparam int unsigned POS_HX = 3;
	localparam int unsigned POS_LX = 4;
	localparam int unsigned NBYTES = 5;

	// request queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = 1;
	localparam int unsigned QCNT_W      = 2;

	typedef struct packed {
		logic [LIMIT_W-1:0] width;
		logic [LIMIT_W-1:0] height;
	} cfg_t;

	// one classified point: field values and which optional bytes go out
	typedef struct packed {
		logic [FIELD_W-1:0] high_y;
		logic [EXTRA_W-1:0] extra;
		logic [FIELD_W-1:0] low_y;
		logic [FIELD_W-1:0] high_x;
		logic [FIELD_W-1:0] low_x;
		logic [NBYTES-2:0]  send;
	} cmd_t;

endpackage

FILE: rtl/vtce_front.sv
// front end: accepts points, clamps them, splits the fields and flags changed bytes
// depends on vtce_pkg
module vtce_front import vtce_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // x_coord [15:0], y_coord [31:16]
	output logic        push,
	output cmd_t        push_cmd,
	input  logic        push_ready
);

	logic [COORD_W-1:0] x_in, y_in, x_cl, y_cl;
	logic [FIELD_W-1:0] hy, ly, hx, lx;
	logic [EXTRA_W-1:0] ex;
	logic               hy_chg, ex_chg, ly_chg, hx_chg;

	logic               prev_valid_q;
	logic [FIELD_W-1:0] prev_hy_q, prev_ly_q, prev_hx_q;
	logic [EXTRA_W-1:0] prev_ex_q;

	// clamp to limit minus one, a zero limit clamps to zero
	function automatic logic [COORD_W-1:0] clamp(input logic [COORD_W-1:0] v,
			input logic [LIMIT_W-1:0] lim);
		logic [COORD_W-1:0] lim_ext;
		lim_ext = {{(COORD_W-LIMIT_W){1'b0}}, lim};
		if (lim == '0) begin
			return '0;
		end else if (v >= lim_ext) begin
			return lim_ext - COORD_W'(1);
		end
		return v;
	endfunction

	assign x_in = s_tdata[15:0];
	assign y_in = s_tdata[31:16];

	// clamp and split into address fields
	always_comb begin
		x_cl = clamp(x_in, cfg.width);
		y_cl = clamp(y_in, cfg.height);
		hy   = y_cl[11:7];
		ly   = y_cl[6:2];
		hx   = x_cl[11:7];
		lx   = x_cl[6:2];
		ex   = {y_cl[1:0], x_cl[1:0]};
	end

	// changed-byte detection, everything differs before the first point
	always_comb begin
		hy_chg = !prev_valid_q || (hy != prev_hy_q);
		ex_chg = !prev_valid_q || (ex != prev_ex_q);
		ly_chg = !prev_valid_q || (ly != prev_ly_q);
		hx_chg = !prev_valid_q || (hx != prev_hx_q);
	end

	always_comb begin
		push_cmd.high_y       = hy;
		push_cmd.extra        = ex;
		push_cmd.low_y        = ly;
		push_cmd.high_x       = hx;
		push_cmd.low_x        = lx;
		push_cmd.send[POS_HY] = hy_chg;
		push_cmd.send[POS_EX] = ex_chg;
		push_cmd.send[POS_LY] = ex_chg || ly_chg || hx_chg;
		push_cmd.send[POS_HX] = hx_chg;
	end

	assign s_tready = push_ready;
	assign push     = s_tvalid && push_ready;

	// last-sent history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_valid_q <= 1'b0;
		end else if (push) begin
			prev_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			prev_hy_q <= hy;
			prev_ex_q <= ex;
			prev_ly_q <= ly;
			prev_hx_q <= hx;
		end
	end

endmodule

FILE: rtl/vtce_queue.sv
// short request queue decoupling the front end from the byte serialiser
// depends on vtce_pkg
module vtce_queue import vtce_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic push_ready,
	output logic pop_valid,
	output cmd_t pop_cmd,
	input  logic pop
);

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = entry_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

FILE: rtl/vtce_back.sv
// back end: serialises one queued request into address bytes through an output register
// depends on vtce_pkg and the assertion macro header
`include "vector_terminal_coord_encoder_defines.svh"

module vtce_back import vtce_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  cmd_t       q_cmd,
	output logic       q_pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // out_byte [6:0], zero [7]
	output logic       m_tlast    // last_byte
);

	cmd_t              cur_q;
	logic [NBYTES-1:0] pend_q;
	logic              cur_valid_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] byte_q;
	logic              last_q;

	logic              out_free, emit, sel_last;
	logic [NBYTES-1:0] sel_mask;
	logic [BYTE_W-1:0] sel_byte;

	assign out_free = !out_valid_q || m_tready;
	assign emit     = cur_valid_q && out_free;
	assign sel_last = (pend_q[NBYTES-2:0] == '0);
	assign q_pop    = q_valid && (!cur_valid_q || (emit && sel_last));

	// pick the first pending byte in wire order
	always_comb begin
		sel_mask = '0;
		sel_byte = TAG_LOW_X | {2'b00, cur_q.low_x};
		if (pend_q[POS_HY]) begin
			sel_mask[POS_HY] = 1'b1;
			sel_byte         = TAG_HIGH | {2'b00, cur_q.high_y};
		end else if (pend_q[POS_EX]) begin
			sel_mask[POS_EX] = 1'b1;
			sel_byte         = TAG_LOW_Y | {3'b000, cur_q.extra};
		end else if (pend_q[POS_LY]) begin
			sel_mask[POS_LY] = 1'b1;
			sel_byte         = TAG_LOW_Y | {2'b00, cur_q.low_y};
		end else if (pend_q[POS_HX]) begin
			sel_mask[POS_HX] = 1'b1;
			sel_byte         = TAG_HIGH | {2'b00, cur_q.high_x};
		end else begin
			sel_mask[POS_LX] = 1'b1;
		end
	end

	// current request and its pending bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			pend_q      <= '0;
		end else if (q_pop) begin
			cur_valid_q <= 1'b1;
			pend_q      <= {1'b1, q_cmd.send};
		end else if (emit) begin
			pend_q <= pend_q & ~sel_mask;
			if (sel_last) begin
				cur_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_cmd;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q <= sel_byte;
			last_q <= sel_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, byte_q};
	assign m_tlast  = last_q;

	// checks
	`VTCE_ASSERT(a_lowx_pending, !cur_valid_q || pend_q[POS_LX], "active request lost its low-x byte")
	`VTCE_ASSERT(a_idle_clean, cur_valid_q || (pend_q == '0), "idle serialiser holds pending bytes")
	`VTCE_ASSERT_NEXT(a_last_marked, emit && sel_last, m_tvalid && m_tlast, "final byte not marked last")

endmodule

FILE: rtl/vector_terminal_coord_encoder.sv
// Vector terminal coordinate encoder: each accepted point (x, y) is clamped to the
// configured screen size and leaves as one to five 7-bit address bytes (high-y, extra,
// low-y, high-x, low-x); low-x always goes, with tlast, low-y also on an extra or
// high-x change, the others only when changed. The single byte-wide output register
// sends them; a two-entry request queue lets new points be taken while earlier bytes
// drain. No clearing pass after reset. Configuration: screen_width at address 0,
// screen_height at address 4, written by the user only while the block is idle; the
// block does not enforce it. Depends on vtce_pkg, vtce_front, vtce_queue and vtce_back
module vector_terminal_coord_encoder import vtce_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// point stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // x_coord [15:0], y_coord [31:16]
	// byte stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_byte [6:0], zero [7]
	output logic        m_tlast    // last_byte
);

	cfg_t cfg_q;
	logic reg_idx;
	logic cfg_wr;
	logic push, push_ready, q_valid, q_pop;
	cmd_t push_cmd, q_cmd;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign cfg_wr  = psel && penable && pwrite;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= LIMIT_W'(4096);
			cfg_q.height <= LIMIT_W'(3072);
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_WIDTH:  cfg_q.width  <= pwdata[LIMIT_W-1:0];
				REG_HEIGHT: cfg_q.height <= pwdata[LIMIT_W-1:0];
				default:    cfg_q        <= cfg_q;
			endcase
		end
	end

	// register read-back
	always_comb begin
		unique case (reg_idx)
			REG_WIDTH:  prdata = {{(32-LIMIT_W){1'b0}}, cfg_q.width};
			REG_HEIGHT: prdata = {{(32-LIMIT_W){1'b0}}, cfg_q.height};
			default:    prdata = '0;
		endcase
	end

	vtce_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.push       (push),
		.push_cmd   (push_cmd),
		.push_ready (push_ready)
	);

	vtce_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.push_ready (push_ready),
		.pop_valid  (q_valid),
		.pop_cmd    (q_cmd),
		.pop        (q_pop)
	);

	vtce_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

FILE: tb/tb.sv
// self-checking testbench for vector_terminal_coord_encoder: points go in on the stream
// port, address bytes come back and are matched against literal bytes or a built-in byte sequence predictor
// depends on vtce_pkg and the rtl of vector_terminal_coord_encoder
`timescale 1ns / 100ps

module tb;
	import vtce_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 28;

	typedef struct packed {
		logic [BYTE_W-1:0] code;
		logic              last;
	} addr_byte_t;

	// one directed point; n_lit of zero means the predictor supplies the bytes
	typedef struct {
		logic [COORD_W-1:0]                  x;
		logic [COORD_W-1:0]                  y;
		int                                  n_lit;
		logic [0:NBYTES-1][BYTE_W-1:0]       lit;
	} point_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // x_coord [15:0], y_coord [31:16]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // out_byte [6:0], zero [7]
	logic        m_tlast;        // last_byte

	// predictor copy of configuration and last-sent fields
	logic [LIMIT_W-1:0] width_lim = 13'd4096;
	logic [LIMIT_W-1:0] height_lim = 13'd3072;
	logic [7:0]         prev_high_y = 8'hff;
	logic [7:0]         prev_extra = 8'hff;
	logic [7:0]         prev_low_y = 8'hff;
	logic [7:0]         prev_high_x = 8'hff;
	logic [COORD_W-1:0] last_cx = '0;
	logic [COORD_W-1:0] last_cy = '0;

	addr_byte_t pending_bytes [$];
	point_row_t directed_rows [$];
	int         fail_count = 0;
	int         send_idle_pct = 0;
	int         recv_idle_pct = 0;
	int         stall_left = 0;
	logic       stall_kick = 1'b0;

	vector_terminal_coord_encoder dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always #10 clk = ~clk;

	// clamp to limit-1, a zero limit pins the coordinate to zero
	function automatic logic [COORD_W-1:0] clamp_coord(logic [COORD_W-1:0] v,
			logic [LIMIT_W-1:0] lim);
		if (lim == '0)
			return '0;
		if (v >= {3'b000, lim})
			return {3'b000, lim} - 16'd1;
		return v;
	endfunction

	// byte sequence of one point, updating the last-sent fields
	task automatic encode_point(input logic [COORD_W-1:0] x_in, input logic [COORD_W-1:0] y_in,
			output int n, output addr_byte_t seq [NBYTES]);
		logic [COORD_W-1:0] cx, cy;
		logic [FIELD_W-1:0] hy, ly, hx, lx;
		logic [EXTRA_W-1:0] ex;
		logic               ex_chg, hx_chg;
		cx = clamp_coord(x_in, width_lim);
		cy = clamp_coord(y_in, height_lim);
		hy = cy[11:7];
		ly = cy[6:2];
		hx = cx[11:7];
		lx = cx[6:2];
		ex = {cy[1:0], cx[1:0]};
		ex_chg = ({4'b0000, ex} != prev_extra);
		hx_chg = ({3'b000, hx} != prev_high_x);
		n = 0;
		if ({3'b000, hy} != prev_high_y) begin
			seq[n] = '{TAG_HIGH | BYTE_W'(hy), 1'b0};
			n++;
		end
		if (ex_chg) begin
			seq[n] = '{TAG_LOW_Y | BYTE_W'(ex), 1'b0};
			n++;
		end
		if (ex_chg || {3'b000, ly} != prev_low_y || hx_chg) begin
			seq[n] = '{TAG_LOW_Y | BYTE_W'(ly), 1'b0};
			n++;
		end
		if (hx_chg) begin
			seq[n] = '{TAG_HIGH | BYTE_W'(hx), 1'b0};
			n++;
		end
		seq[n] = '{TAG_LOW_X | BYTE_W'(lx), 1'b1};
		n++;
		prev_high_y = {3'b000, hy};
		prev_extra = {4'b0000, ex};
		prev_low_y = {3'b000, ly};
		prev_high_x = {3'b000, hx};
		last_cx = cx;
		last_cy = cy;
	endtask

	// offer one point, with random idle cycles ahead of it
	task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
			input int n_lit, input logic [0:NBYTES-1][BYTE_W-1:0] lit);
		int n;
		addr_byte_t seq [NBYTES];
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {y, x};
		do @(posedge clk); while (!s_tready);
		encode_point(x, y, n, seq);
		if (n_lit > 0) begin
			for (int i = 0; i < n_lit; i++)
				pending_bytes.push_back('{lit[i], (i == n_lit - 1)});
		end else begin
			for (int i = 0; i < n; i++)
				pending_bytes.push_back(seq[i]);
		end
	endtask

	// stop offering and wait for every expected byte
	task automatic drain_points();
		s_tvalid <= 1'b0;
		while (pending_bytes.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic reg_idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (reg_idx == REG_WIDTH)
			width_lim = value[LIMIT_W-1:0];
		else
			height_lim = value[LIMIT_W-1:0];
	endtask

	// next random coordinate: full range, single-bit flips, small moves, near the limit, or repeated
	function automatic logic [COORD_W-1:0] pick_coord(logic [COORD_W-1:0] base,
			logic [LIMIT_W-1:0] lim);
		case ($urandom_range(9))
			0, 1:    return COORD_W'($urandom_range(16'hffff));
			2, 3, 4: return base ^ (16'd1 << $urandom_range(11));
			5, 6:    return base ^ COORD_W'($urandom_range(3));
			7:       return {3'b000, lim} + COORD_W'($urandom_range(2)) - 16'd1;
			default: return base;
		endcase
	endfunction

	// reconfigure while idle, then a run of random points, optionally behind a receiver hold or with a drain midway
	task automatic run_phase(input logic [31:0] w, input logic [31:0] h, input bit hold,
			input bit mid_drain);
		logic [0:NBYTES-1][BYTE_W-1:0] no_lit;
		no_lit = '0;
		drain_points();
		repeat (8) @(posedge clk);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		if (hold) begin
			stall_kick <= 1'b1;
			@(posedge clk);
			stall_kick <= 1'b0;
		end
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			if (mid_drain && i == PHASE_ITEMS / 2)
				drain_points();
			send_point(pick_coord(last_cx, width_lim), pick_coord(last_cy, height_lim),
				0, no_lit);
		end
	endtask

	// output side: check each accepted byte, then pick the next tready
	always @(posedge clk) begin
		addr_byte_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_bytes.size() == 0) begin
				if (fail_count < 10)
					$display("unexpected byte %h last %b", m_tdata, m_tlast);
				fail_count++;
			end else begin
				want = pending_bytes.pop_front();
				if (m_tdata !== {1'b0, want.code} || m_tlast !== want.last) begin
					if (fail_count < 10)
						$display("byte mismatch: expected %h last %b, got %h last %b",
							{1'b0, want.code}, want.last, m_tdata, m_tlast);
					fail_count++;
				end
			end
		end
		if (stall_kick)
			stall_left = HOLD_CYCLES;
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog on cycles with no request moving anywhere
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
				quiet = 0;
			else
				quiet++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// main sequence
	initial begin
		// after reset the screen is 4096 by 3072 and every byte counts as changed
		directed_rows.push_back('{16'd0, 16'd0, 5, {7'h20, 7'h60, 7'h60, 7'h20, 7'h40}});
		directed_rows.push_back('{16'd0, 16'd0, 1, {7'h40, 7'h00, 7'h00, 7'h00, 7'h00}});
		// top of both ranges clamps to 4095, 3071
		directed_rows.push_back('{16'hffff, 16'hffff, 5,
			{7'h37, 7'h6f, 7'h7f, 7'h3f, 7'h5f}});
		directed_rows.push_back('{16'hffff, 16'hffff, 1, {7'h5f, 7'h00, 7'h00, 7'h00, 7'h00}});
		directed_rows.push_back('{16'd4096, 16'd3072, 1, {7'h5f, 7'h00, 7'h00, 7'h00, 7'h00}});
		directed_rows.push_back('{16'd4095, 16'd3071, 1, {7'h5f, 7'h00, 7'h00, 7'h00, 7'h00}});
		// single-field changes: extra, low-x, low-y, high-x, high-y
		directed_rows.push_back('{16'd4094, 16'd3071, 0, '0});
		directed_rows.push_back('{16'd4090, 16'd3071, 0, '0});
		directed_rows.push_back('{16'd4090, 16'd3059, 0, '0});
		directed_rows.push_back('{16'd3194, 16'd3059, 0, '0});
		directed_rows.push_back('{16'd3194, 16'd2035, 0, '0});
		directed_rows.push_back('{16'd127, 16'd3000, 0, '0});
		directed_rows.push_back('{16'd128, 16'd3000, 0, '0});
		directed_rows.push_back('{16'd128, 16'd4, 0, '0});
		directed_rows.push_back('{16'd128, 16'd128, 0, '0});
		// alternating bit patterns and lone high bits
		directed_rows.push_back('{16'h8000, 16'h0001, 0, '0});
		directed_rows.push_back('{16'h5555, 16'haaaa, 0, '0});
		directed_rows.push_back('{16'haaaa, 16'h5555, 0, '0});
		directed_rows.push_back('{16'd3, 16'd3072, 0, '0});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender idles lightly, receiver heavily
		send_idle_pct = 14;
		recv_idle_pct = 47;
		foreach (directed_rows[i])
			send_point(directed_rows[i].x, directed_rows[i].y, directed_rows[i].n_lit,
				directed_rows[i].lit);
		run_phase(32'd4096, 32'd3072, 1'b0, 1'b0);
		run_phase(32'd1, 32'd1, 1'b1, 1'b0);

		// the other way round
		send_idle_pct = 47;
		recv_idle_pct = 14;
		run_phase(32'($urandom_range(1, 4096)), 32'($urandom_range(1, 4096)), 1'b0, 1'b0);
		run_phase(32'd0, 32'd8191, 1'b1, 1'b0);

		// no idling on either side
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_phase(32'd8191, 32'd0, 1'b0, 1'b1);
		run_phase(32'd4096, 32'd4096, 1'b0, 1'b0);

		drain_points();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending_bytes.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
